@@ hdl/waveform_ring_unwrap_macros.svh @@
// Assertion macros for the checker file of the ring unwrap block
`ifndef WAVEFORM_RING_UNWRAP_MACROS_SVH
`define WAVEFORM_RING_UNWRAP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define WRU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/wru_pkg.sv @@
// Package: field widths, function codes and command struct of the ring unwrap block
`default_nettype none
package wru_pkg;

    localparam int FUNC_W     = 2;
    localparam int POS_W      = 8;
    localparam int SAMPLE_W   = 16;
    localparam int VCOUNT_W   = 9;
    localparam int OFFSET_W   = 8;

    localparam int RECORD_LEN_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    // function codes of an input item
    localparam logic [FUNC_W-1:0] FUNC_STORE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_HEADER = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic cfg_we;    // load wrap offset
        logic store_we;  // write one sample
        logic hdr_we;    // load record header
        logic pos_ld;    // capture read position
        logic seg_en;    // compute segment lengths and bases
        logic addr_en;   // compute valid count, hit and store address
        logic rd_en;     // read sample store
        logic out_ld;    // load result register
    } wru_cmd_t;

endpackage
`default_nettype wire

@@ hdl/wru_ram.sv @@
// Generic single-port RAM with registered read
`default_nettype none
module wru_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port share the address
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ hdl/wru_ctrl.sv @@
// Controller: sequences store, header and read transfers of the ring unwrap block
`default_nettype none
module wru_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [wru_pkg::FUNC_W-1:0]   func,
    input  wire logic                         cfg_valid,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output wru_pkg::wru_cmd_t                 cmd
);
    import wru_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SEG  = 3'd1;
    localparam logic [2:0] ST_ADDR = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_xfer;
    logic       can_load;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign can_load = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (func == FUNC_READ))
                begin
                    state_next = ST_SEG;
                end
            end
            ST_SEG:  state_next = ST_ADDR;
            ST_ADDR: state_next = ST_READ;
            ST_READ: state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd          = '0;
        cmd.cfg_we   = cfg_valid;
        cmd.store_we = in_xfer && (func == FUNC_STORE);
        cmd.hdr_we   = in_xfer && (func == FUNC_HEADER);
        cmd.pos_ld   = in_xfer && (func == FUNC_READ);
        cmd.seg_en   = (state_reg == ST_SEG);
        cmd.addr_en  = (state_reg == ST_ADDR);
        cmd.rd_en    = (state_reg == ST_READ);
        cmd.out_ld   = (state_reg == ST_LOAD) && can_load;
    end

    // result held until transferred
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_ld)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

@@ hdl/wru_datapath.sv @@
// Datapath: header, offset, sample store and unwrap address arithmetic
`default_nettype none
module wru_datapath #(
    parameter int RECORD_LEN  = wru_pkg::RECORD_LEN_DEF,
    parameter int SAMPLE_BITS = wru_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire wru_pkg::wru_cmd_t                  cmd,
    input  wire logic [wru_pkg::POS_W-1:0]          position,
    input  wire logic signed [wru_pkg::SAMPLE_W-1:0] sample_value,
    input  wire logic [wru_pkg::POS_W-1:0]          first_hitbus,
    input  wire logic [wru_pkg::POS_W-1:0]          last_hitbus,
    input  wire logic                               wrapped,
    input  wire logic [wru_pkg::OFFSET_W-1:0]       cfg_data,
    output logic signed [wru_pkg::SAMPLE_W-1:0]     out_sample,
    output logic [wru_pkg::VCOUNT_W-1:0]            valid_count,
    output logic                                    in_range
);
    import wru_pkg::*;

    localparam int AW = $clog2(RECORD_LEN);
    // wide enough for a full record plus one header span
    localparam int VW = $clog2(RECORD_LEN + 257);
    localparam logic [VW-1:0] RL_V = VW'(RECORD_LEN);

    // header and configuration
    logic [POS_W-1:0]    first_reg, last_reg;
    logic                wrap_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [POS_W-1:0]    pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            last_reg   <= '0;
            wrap_reg   <= 1'b0;
            offset_reg <= '0;
        end
        else
        begin
            if (cmd.hdr_we)
            begin
                first_reg <= first_hitbus;
                last_reg  <= last_hitbus;
                wrap_reg  <= wrapped;
            end
            if (cmd.cfg_we)
            begin
                offset_reg <= cfg_data;
            end
        end
    end

    // segment stage
    logic [VW-1:0] first_v, last_v, off_v, first_p1, last_p1, first_c, last_c;
    logic [VW-1:0] seg_a_next, seg_b_next, base_a_next;
    logic [VW-1:0] seg_a_reg, seg_b_reg, base_a_reg, base_b_reg;

    always_comb
    begin
        first_v  = VW'(first_reg);
        last_v   = VW'(last_reg);
        off_v    = VW'(offset_reg);
        first_p1 = first_v + VW'(1);
        last_p1  = last_v + VW'(1);
        first_c  = (first_v < RL_V) ? first_v : RL_V;
        last_c   = (last_v < RL_V) ? last_v : RL_V;
        if (!wrap_reg)
        begin
            // tail of record after last mark, then start up to first mark
            seg_a_next  = (RL_V > last_p1) ? (RL_V - last_p1) : '0;
            seg_b_next  = (first_c > off_v) ? (first_c - off_v) : '0;
            base_a_next = last_p1;
        end
        else
        begin
            // one span strictly between the marks
            seg_a_next  = (last_c > first_p1) ? (last_c - first_p1) : '0;
            seg_b_next  = '0;
            base_a_next = first_p1;
        end
    end

    // address stage
    logic [VW-1:0] pos_v, seg_sum, valid_next, addr_full;
    logic [VW-1:0] valid_reg;
    logic [AW-1:0] addr_reg;
    logic          hit_reg;

    always_comb
    begin
        pos_v      = VW'(pos_reg);
        seg_sum    = seg_a_reg + seg_b_reg;
        valid_next = (seg_sum < RL_V) ? seg_sum : RL_V;
        if (pos_v < seg_a_reg)
        begin
            addr_full = base_a_reg + pos_v;
        end
        else
        begin
            addr_full = base_b_reg + pos_v - seg_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pos_ld)
        begin
            pos_reg <= position;
        end
        if (cmd.seg_en)
        begin
            seg_a_reg  <= seg_a_next;
            seg_b_reg  <= seg_b_next;
            base_a_reg <= base_a_next;
            base_b_reg <= off_v;
        end
        if (cmd.addr_en)
        begin
            valid_reg <= valid_next;
            hit_reg   <= (pos_v < valid_next);
            addr_reg  <= addr_full[AW-1:0];
        end
    end

    // sample store
    logic [VW-1:0]          wr_pos_v;
    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    assign wr_pos_v = VW'(position);
    assign ram_we   = cmd.store_we && (wr_pos_v < RL_V);
    assign ram_addr = cmd.rd_en ? addr_reg : wr_pos_v[AW-1:0];

    wru_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RECORD_LEN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (cmd.rd_en),
        .addr  (ram_addr),
        .wdata (sample_value[SAMPLE_BITS-1:0]),
        .rdata (ram_rdata)
    );

    // result register, sample sign-extended, zero when out of range
    logic signed [SAMPLE_BITS-1:0] rd_signed;
    logic signed [SAMPLE_W-1:0]    sample_ext;
    logic signed [SAMPLE_W-1:0]    out_sample_reg;
    logic [VCOUNT_W-1:0]           valid_count_reg;
    logic                          in_range_reg;

    assign rd_signed  = $signed(ram_rdata);
    assign sample_ext = SAMPLE_W'(rd_signed);

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            out_sample_reg  <= hit_reg ? sample_ext : '0;
            valid_count_reg <= valid_reg[VCOUNT_W-1:0];
            in_range_reg    <= hit_reg;
        end
    end

    assign out_sample  = out_sample_reg;
    assign valid_count = valid_count_reg;
    assign in_range    = in_range_reg;

endmodule
`default_nettype wire

@@ hdl/waveform_ring_unwrap.sv @@
// Top level: circular waveform record with unwrapped read-out
`default_nettype none
// One channel's circular sample record. A store transfer (func 0) writes a
// sample at its store position and a header transfer (func 1) loads the first
// and last hit-bus marks and the wrap flag; after either, the next item is
// accepted in the following cycle. A read transfer (func 2) maps the unwrapped
// position onto the store and offers the sample, the valid count and the
// in-range flag after its segment stage, address stage, registered RAM read
// and result load; the next item is accepted right after the result is
// loaded. The result sits in an output register until out_ready; stores and
// headers keep flowing meanwhile, but a following read waits in its load step
// until that register is free. The wrap offset register is written through
// the cfg port; the user must write it only while idle, the block itself does not enforce this.
module waveform_ring_unwrap #(
    parameter int RECORD_LEN  = wru_pkg::RECORD_LEN_DEF,
    parameter int SAMPLE_BITS = wru_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [wru_pkg::FUNC_W-1:0]          func,
    input  wire logic [wru_pkg::POS_W-1:0]           position,
    input  wire logic signed [wru_pkg::SAMPLE_W-1:0] sample_value,
    input  wire logic [wru_pkg::POS_W-1:0]           first_hitbus,
    input  wire logic [wru_pkg::POS_W-1:0]           last_hitbus,
    input  wire logic                                wrapped,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [wru_pkg::SAMPLE_W-1:0]      out_sample,
    output logic [wru_pkg::VCOUNT_W-1:0]             valid_count,
    output logic                                     in_range,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [wru_pkg::OFFSET_W-1:0]        cfg_data
);
    import wru_pkg::*;

    wru_cmd_t cmd;

    // offset register takes every write at once
    assign cfg_ready = 1'b1;

    wru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .cfg_valid (cfg_valid),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    wru_datapath #(
        .RECORD_LEN  (RECORD_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .position     (position),
        .sample_value (sample_value),
        .first_hitbus (first_hitbus),
        .last_hitbus  (last_hitbus),
        .wrapped      (wrapped),
        .cfg_data     (cfg_data),
        .out_sample   (out_sample),
        .valid_count  (valid_count),
        .in_range     (in_range)
    );

endmodule
`default_nettype wire

@@ hdl/wru_checker.sv @@
// Port-level checker for the ring unwrap block, bound to the top level
`include "waveform_ring_unwrap_macros.svh"
`default_nettype none
module wru_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic [wru_pkg::FUNC_W-1:0]          func,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic signed [wru_pkg::SAMPLE_W-1:0] out_sample,
    input wire logic [wru_pkg::VCOUNT_W-1:0]        valid_count,
    input wire logic                                in_range
);
    import wru_pkg::*;

    // stalled result holds
    `WRU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample) && $stable(valid_count) && $stable(in_range), "result changed while stalled")

    // out-of-range reads return zero
    `WRU_ASSERT_IMPL(a_zero_fill, out_valid && !in_range, out_sample == '0, "nonzero sample out of range")

    // a hit needs a nonempty record
    `WRU_ASSERT_IMPL(a_hit_count, out_valid && in_range, valid_count != '0, "hit with empty record")

    // a read keeps the input closed while it is computed
    `WRU_ASSERT_NEXT(a_read_busy, in_valid && in_ready && (func == FUNC_READ), !in_ready, "input open during read")

endmodule

bind waveform_ring_unwrap wru_checker u_wru_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_sample  (out_sample),
    .valid_count (valid_count),
    .in_range    (in_range)
);
`default_nettype wire
